// ===== rtl/sam_pkg.sv =====
// Package for the sprite affine matrix: types, constants, the arctangent table and saturation.
`default_nettype none
package sam_pkg;

  localparam int CORDIC_STAGES = 18;
  localparam int XW            = 34;
  localparam int ZW            = 36;
  localparam int LATENCY       = CORDIC_STAGES + 7;

  localparam logic signed [XW-1:0] GAIN_INIT  = XW'(652032874);
  localparam logic [24:0]          DEG360_Q16 = 25'd23592960;
  localparam logic [24:0]          DEG180_Q16 = 25'd11796480;
  localparam logic signed [26:0]   DEG90_Q16  = 27'sd5898240;
  localparam logic signed [26:0]   DEG180_S   = 27'sd11796480;
  localparam logic [15:0]          RECIP_360  = 16'd46603;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] rotation_degrees;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
  } sam_req_t;

  typedef struct packed {
    logic signed [23:0] coef_xx;
    logic signed [23:0] coef_xy;
    logic signed [23:0] coef_yx;
    logic signed [23:0] coef_yy;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic [24:0]        angle_normalized;
  } sam_rsp_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(754974720);
      1:  v = ZW'(445687602);
      2:  v = ZW'(235489088);
      3:  v = ZW'(119537938);
      4:  v = ZW'(60000934);
      5:  v = ZW'(30029717);
      6:  v = ZW'(15018523);
      7:  v = ZW'(7509720);
      8:  v = ZW'(3754917);
      9:  v = ZW'(1877466);
      10: v = ZW'(938734);
      11: v = ZW'(469367);
      12: v = ZW'(234684);
      13: v = ZW'(117342);
      14: v = ZW'(58671);
      15: v = ZW'(29335);
      16: v = ZW'(14668);
      17: v = ZW'(7334);
      18: v = ZW'(3667);
      19: v = ZW'(1833);
      20: v = ZW'(917);
      21: v = ZW'(458);
      22: v = ZW'(229);
      23: v = ZW'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -64'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sam_cordic.sv =====
// Rotation-mode CORDIC, one registered stage per iteration.
`default_nettype none
module sam_cordic
  import sam_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic signed [ZW-1:0] z_in,
  output logic signed [XW-1:0]      x_out,
  output logic signed [XW-1:0]      y_out
);

  logic signed [XW-1:0] x [0:CORDIC_STAGES];
  logic signed [XW-1:0] y [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z [0:CORDIC_STAGES];

  assign x[0] = GAIN_INIT;
  assign y[0] = '0;
  assign z[0] = z_in;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    always_ff @(posedge clk) begin
      if (!z[i][ZW-1]) begin
        x[i+1] <= x[i] - ys;
        y[i+1] <= y[i] + xs;
        z[i+1] <= z[i] - atan_q24(i);
      end else begin
        x[i+1] <= x[i] + ys;
        y[i+1] <= y[i] - xs;
        z[i+1] <= z[i] + atan_q24(i);
      end
    end
  end

  assign x_out = x[CORDIC_STAGES];
  assign y_out = y[CORDIC_STAGES];

endmodule
`default_nettype wire

// ===== rtl/sprite_affine_matrix.sv =====
// Top level of the sprite affine matrix pipeline.
//   channel   direction  handshake           payload
//   request   in         start, busy         request (sam_req_t)
//   result    out        done strobe         result  (sam_rsp_t)
// One request per cycle; busy stays low, the pipeline never stalls.
// Registered steps in order: angle reduction, the CORDIC stages, sign fix,
// coefficient multiply, rounding, translation multiply and translation sum.
// Reset clears the valid bits only.
// The receiver cannot stall; each result shows for one cycle with done.
`default_nettype none
module sprite_affine_matrix
  import sam_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire sam_req_t  request,
  output logic           done,
  output sam_rsp_t       result
);

  typedef struct packed {
    sam_req_t    req;
    logic [24:0] a;
    logic        flip;
  } side_t;

  logic         v1;
  sam_req_t     req1;
  logic [31:0]  q_prod;

  logic         v2;
  side_t        side2;
  logic signed [ZW-1:0] z2;

  logic         sv [1:CORDIC_STAGES];
  side_t        side [1:CORDIC_STAGES];

  logic signed [XW-1:0] cx, cy;

  logic         v3;
  side_t        side3;
  logic signed [XW-1:0] x3, y3;

  logic         v4;
  side_t        side4;
  logic signed [57:0] p_sxc, p_syc, p_sxs, p_sys;

  logic         v5;
  side_t        side5;
  logic signed [23:0] sxc, syc, sxs, sys;

  logic         v6;
  side_t        side6;
  logic signed [23:0] c_xx, c_xy, c_yx, c_yy;
  logic signed [55:0] t_oxc, t_oys, t_oxs, t_oyc;

  logic [15:0]  u1;
  logic [8:0]   q1;
  logic [9:0]   r_raw, r_red;
  logic [8:0]   hmod;
  logic [24:0]  a_c;
  logic signed [26:0] d_c, d_f;
  logic         flip_c;
  logic signed [63:0] tx_sum, ty_sum;

  assign busy = 1'b0;
  assign u1 = {~request.rotation_degrees[31], request.rotation_degrees[30:16]};

  always_comb begin
    q1    = {1'b0, q_prod[31:24]};
    r_raw = 10'({~req1.rotation_degrees[31], req1.rotation_degrees[30:16]} - 16'(q1 * 10'd360));
    r_red = (r_raw >= 10'd360) ? r_raw - 10'd360 : r_raw;
    hmod  = (r_red < 10'd8) ? 9'(r_red + 10'd352) : 9'(r_red - 10'd8);
    a_c   = {hmod, req1.rotation_degrees[15:0]};
    if (a_c > DEG180_Q16) begin
      d_c = 27'(DEG360_Q16) - 27'(a_c);
    end else begin
      d_c = -27'(a_c);
    end
    flip_c = 1'b0;
    d_f    = d_c;
    if (d_c < -DEG90_Q16) begin
      d_f    = d_c + DEG180_S;
      flip_c = 1'b1;
    end else if (d_c > DEG90_Q16) begin
      d_f    = d_c - DEG180_S;
      flip_c = 1'b1;
    end
  end

  sam_cordic u_cordic (
    .clk   (clk),
    .z_in  (z2),
    .x_out (cx),
    .y_out (cy)
  );

  always_comb begin
    tx_sum = -64'(t_oxc) - 64'(t_oys) + (64'(side6.req.position_x) <<< 16) + 64'sd32768;
    ty_sum = 64'(t_oxs) - 64'(t_oyc) + (64'(side6.req.position_y) <<< 16) + 64'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      done <= 1'b0;
      for (int k = 1; k <= CORDIC_STAGES; k++) begin
        sv[k] <= 1'b0;
      end
    end else begin
      v1    <= start && !busy;
      v2    <= v1;
      sv[1] <= v2;
      for (int k = 2; k <= CORDIC_STAGES; k++) begin
        sv[k] <= sv[k-1];
      end
      v3   <= sv[CORDIC_STAGES];
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      done <= v6;
    end

    req1   <= request;
    q_prod <= 32'(u1 * RECIP_360);

    side2.req  <= req1;
    side2.a    <= a_c;
    side2.flip <= flip_c;
    z2         <= ZW'(d_f) <<< 8;

    side[1] <= side2;
    for (int k = 2; k <= CORDIC_STAGES; k++) begin
      side[k] <= side[k-1];
    end

    side3 <= side[CORDIC_STAGES];
    x3    <= side[CORDIC_STAGES].flip ? -cx : cx;
    y3    <= side[CORDIC_STAGES].flip ? -cy : cy;

    side4 <= side3;
    p_sxc <= side3.req.scale_x * x3;
    p_syc <= side3.req.scale_y * x3;
    p_sxs <= side3.req.scale_x * y3;
    p_sys <= side3.req.scale_y * y3;

    side5 <= side4;
    sxc   <= sat24((64'(p_sxc) + 64'sd536870912) >>> 30);
    syc   <= sat24((64'(p_syc) + 64'sd536870912) >>> 30);
    sxs   <= sat24((64'(p_sxs) + 64'sd536870912) >>> 30);
    sys   <= sat24((64'(p_sys) + 64'sd536870912) >>> 30);

    side6 <= side5;
    c_xx  <= sxc;
    c_xy  <= sys;
    c_yx  <= sat24(-64'(sxs));
    c_yy  <= syc;
    t_oxc <= side5.req.origin_x * sxc;
    t_oys <= side5.req.origin_y * sys;
    t_oxs <= side5.req.origin_x * sxs;
    t_oyc <= side5.req.origin_y * syc;

    result.coef_xx          <= c_xx;
    result.coef_xy          <= c_xy;
    result.coef_yx          <= c_yx;
    result.coef_yy          <= c_yy;
    result.trans_x          <= sat32(tx_sum >>> 16);
    result.trans_y          <= sat32(ty_sum >>> 16);
    result.angle_normalized <= side6.a;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("request did not produce a result after the pipeline latency");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.angle_normalized < DEG360_Q16))
    else $error("normalized angle out of range");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

  a_coef_yx_neg: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.coef_yx != -24'sd8388608))
    else $error("negated coefficient reached the negative limit");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for sprite_affine_matrix: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import sam_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  sam_req_t request;
  logic     done;
  sam_rsp_t result;

  sam_req_t pending_q[$];
  sam_rsp_t expected_q[$];
  int       errors;
  bit       stim_done;
  int       gap;

  localparam int TBL_LEN = 24;
  localparam longint ATAN_DEG[TBL_LEN] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115};

  sprite_affine_matrix uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint scale_trig(longint sc, longint tr);
    return clamp(fshr(sc * tr + (longint'(1) <<< 29), 30), 24);
  endfunction

  function automatic sam_rsp_t affine_of(sam_req_t r);
    sam_rsp_t o;
    longint a, d, x, y, z, nx, ny, sxc, syc, sxs, sys, tx, ty;
    longint px, py, ox, oy, sx, sy;
    bit flip;
    px = r.position_x; py = r.position_y; ox = r.origin_x; oy = r.origin_y;
    sx = r.scale_x; sy = r.scale_y;
    a = longint'(r.rotation_degrees) % 23592960;
    if (a < 0) a += 23592960;
    d = -a;
    flip = 0;
    if (d < -11796480) d += 23592960;
    if (d < -5898240) begin
      d += 11796480; flip = 1;
    end else if (d > 5898240) begin
      d -= 11796480; flip = 1;
    end
    x = 652032874; y = 0; z = d * 256;
    for (int i = 0; i < CORDIC_STAGES && i < TBL_LEN; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i); ny = y + fshr(x, i); z -= ATAN_DEG[i];
      end else begin
        nx = x + fshr(y, i); ny = y - fshr(x, i); z += ATAN_DEG[i];
      end
      x = nx; y = ny;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sxc = scale_trig(sx, x); syc = scale_trig(sy, x);
    sxs = scale_trig(sx, y); sys = scale_trig(sy, y);
    tx = -ox * sxc - oy * sys + px * 65536;
    ty = ox * sxs - oy * syc + py * 65536;
    o.coef_xx = sxc[23:0];
    o.coef_xy = sys[23:0];
    o.coef_yx = 24'(clamp(-sxs, 24));
    o.coef_yy = syc[23:0];
    o.trans_x = 32'(clamp(fshr(tx + 32768, 16), 32));
    o.trans_y = 32'(clamp(fshr(ty + 32768, 16), 32));
    o.angle_normalized = a[24:0];
    return o;
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'(int'($urandom_range(0, 131072)) - 65536);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return 32'(int'($urandom_range(0, 8)) * 5898240 - 23592960
                    + int'($urandom_range(0, 2)) - 1);
      1: return 32'(int'($urandom_range(0, 47185920)) - 23592960);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic [31:0] px, logic [31:0] py, logic [31:0] rot,
                         logic [23:0] sx, logic [23:0] sy,
                         logic [31:0] ox, logic [31:0] oy);
    sam_req_t r;
    r.position_x = px; r.position_y = py; r.rotation_degrees = rot;
    r.scale_x = sx; r.scale_y = sy; r.origin_x = ox; r.origin_y = oy;
    pending_q.push_back(r);
  endtask

  initial begin
    int angs[12];
    angs = '{0, 5898240, 11796480, 17694720, 23592960, -5898240, -11796480,
             5898239, 5898241, 11796479, 23592959, 23592961};
    foreach (angs[k]) add_req(0, 0, angs[k], 24'h010000, 24'h010000, 0, 0);
    add_req(32'h7fffffff, 32'h80000000, 32'h7fffffff, 24'h7fffff, 24'h800000,
            32'h7fffffff, 32'h80000000);
    add_req(32'h80000000, 32'h7fffffff, 32'h80000000, 24'h800000, 24'h7fffff,
            32'h80000000, 32'h7fffffff);
    add_req(32'h7fffffff, 32'h7fffffff, 0, 24'h7fffff, 24'h7fffff,
            32'h80000000, 32'h80000000);
    add_req(32'h80000000, 32'h80000000, 32'h00b40000, 24'h800000, 24'h800000,
            32'h7fffffff, 32'h7fffffff);
    add_req(32'hffffffff, 32'hffffffff, 32'hffffffff, 24'hffffff, 24'hffffff,
            32'hffffffff, 32'hffffffff);
    add_req(32'h00010000, 32'h00020000, 32'h002d0000, 24'h020000, 24'h008000,
            32'h00100000, 32'h00080000);
    add_req(0, 0, 32'h005a0000, 0, 0, 0, 0);
    for (int n = 0; n < 1800; n++)
      add_req(rand32(), rand32(), rand_angle(), rand_scale(), rand_scale(),
              rand32(), rand32());
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      request <= '0;
      gap <= 0;
      stim_done <= 1'b0;
    end else if (start && busy) begin
      // hold
    end else begin
      if (start) expected_q.push_back(affine_of(request));
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        start <= 1'b1;
        request <= pending_q.pop_front();
        case ($urandom_range(0, 9))
          0, 1: gap <= $urandom_range(1, 3);
          2: gap <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : 0;
          default: gap <= 0;
        endcase
      end else begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sam_rsp_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result.coef_xx !== e.coef_xx) begin
          $error("coef_xx exp %0d got %0d", e.coef_xx, result.coef_xx); errors++;
        end
        if (result.coef_xy !== e.coef_xy) begin
          $error("coef_xy exp %0d got %0d", e.coef_xy, result.coef_xy); errors++;
        end
        if (result.coef_yx !== e.coef_yx) begin
          $error("coef_yx exp %0d got %0d", e.coef_yx, result.coef_yx); errors++;
        end
        if (result.coef_yy !== e.coef_yy) begin
          $error("coef_yy exp %0d got %0d", e.coef_yy, result.coef_yy); errors++;
        end
        if (result.trans_x !== e.trans_x) begin
          $error("trans_x exp %0d got %0d", e.trans_x, result.trans_x); errors++;
        end
        if (result.trans_y !== e.trans_y) begin
          $error("trans_y exp %0d got %0d", e.trans_y, result.trans_y); errors++;
        end
        if (result.angle_normalized !== e.angle_normalized) begin
          $error("angle_normalized exp %0d got %0d", e.angle_normalized,
                 result.angle_normalized);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait (stim_done && expected_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("sprite_affine_matrix: match");
    end else begin
      $display("sprite_affine_matrix: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sprite_affine_matrix: mismatch");
    $finish;
  end

endmodule
